// ----- hdl/sfrp_pkg.sv -----
// shared types and constants of the server failover retry policy block
// no dependencies; used by sfrp_policy and server_failover_retry_policy
package sfrp_pkg;

  localparam int OP_W     = 2;
  localparam int STAT_W   = 3;
  localparam int TIME_W   = 48;
  localparam int SRVF_W   = 3;
  localparam int TMO_W    = 32;
  localparam int DLY_W    = 27;
  localparam int ACT_W    = 3;
  localparam int CNT32_W  = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [OP_W-1:0] {
    OP_START       = 2'd0,
    OP_RESULT      = 2'd1,
    OP_SET_WORKING = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_SUCCESS   = 3'd0,
    ST_HOST_DOWN = 3'd1,
    ST_RESET     = 3'd2,
    ST_TIMED_OUT = 3'd3,
    ST_OTHER     = 3'd4
  } status_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_ISSUE        = 3'd0,
    ACT_DONE_OK      = 3'd1,
    ACT_DONE_EXPIRED = 3'd2,
    ACT_UPDATE_ACK   = 3'd3,
    ACT_IGNORED      = 3'd4
  } action_e;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIMEOUT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILS_SWITCH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRIES_WAIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_IVL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT  = 3'd6;

  localparam logic [9:0] US_PER_MS = 10'd1000;

  typedef struct packed {
    logic [31:0] base_timeout_ms;
    logic [31:0] max_timeout_ms;
    logic [15:0] fails_before_switch;
    logic [15:0] retries_before_wait;
    logic [15:0] long_wait_ms;
    logic [23:0] retry_interval_us;
    logic [3:0]  server_count;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [STAT_W-1:0] status_class;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] budget_ms;
    logic [SRVF_W-1:0] new_working_server;
  } item_t;

  typedef struct packed {
    action_e           action;
    logic [SRVF_W-1:0] server_index;
    logic [TMO_W-1:0]  attempt_timeout_ms;
    logic [DLY_W-1:0]  delay_us;
  } result_t;

  // request bookkeeping apart from the server indexes
  typedef struct packed {
    logic [CNT32_W-1:0] fails_on_server;
    logic [CNT32_W-1:0] retries_total;
    logic [TMO_W-1:0]   current_timeout_ms;
    logic [TIME_W-1:0]  start_time_ms;
    logic [TIME_W-1:0]  retry_budget_ms;
    logic               request_active;
  } req_state_t;

endpackage

// ----- hdl/sfrp_policy.sv -----
// next-state and result logic for one word of the retry policy
// depends on sfrp_pkg; purely combinational, state registers live in the top level
module sfrp_policy #(
  parameter int MAX_SERVERS = 8,
  parameter int SRV_W       = 3,
  parameter int CW          = 4
) (
  input  sfrp_pkg::cfg_t       cfg_i,
  input  sfrp_pkg::item_t      item_i,
  input  sfrp_pkg::req_state_t st_i,
  input  logic [SRV_W-1:0]     working_i,
  input  logic [SRV_W-1:0]     seen_i,
  input  logic [SRV_W-1:0]     trying_i,
  output sfrp_pkg::req_state_t st_o,
  output logic [SRV_W-1:0]     working_o,
  output logic [SRV_W-1:0]     seen_o,
  output logic [SRV_W-1:0]     trying_o,
  output sfrp_pkg::result_t    res_o
);

  logic [CW-1:0]                eff_count;
  logic [CW-1:0]                sc_ext;
  logic                         unlimited;
  logic                         host_down;
  logic                         link_reset;
  logic                         tmo_status;
  logic [sfrp_pkg::CNT32_W-1:0] retries_inc;
  logic [sfrp_pkg::CNT32_W-1:0] fails_inc;
  logic                         wait_long;
  logic                         fails_hit;
  logic                         change;
  logic                         timed_out;
  logic [sfrp_pkg::TMO_W:0]     dbl;
  logic [sfrp_pkg::TMO_W:0]     clamp_hi;
  logic [sfrp_pkg::TMO_W:0]     clamp_lo;
  logic [CW-1:0]                inc_srv;
  logic [CW-1:0]                wrap_srv;
  logic                         seen_match;
  logic [SRV_W-1:0]             next_srv;
  logic                         same_srv;
  logic [sfrp_pkg::DLY_W-1:0]   long_part;
  logic [sfrp_pkg::DLY_W-1:0]   delay;
  logic [sfrp_pkg::TIME_W-1:0]  elapsed;
  logic                         expired;
  logic [sfrp_pkg::TMO_W-1:0]   cur_next;
  logic [SRV_W+2:0]             trying_ext;
  logic [SRV_W+2:0]             next_ext;

  // ring size, zero taken as one, clamped to the build limit
  assign sc_ext = CW'(cfg_i.server_count);
  always_comb begin
    if (sc_ext == '0) begin
      eff_count = CW'(1);
    end else if (sc_ext > CW'(MAX_SERVERS)) begin
      eff_count = CW'(MAX_SERVERS);
    end else begin
      eff_count = sc_ext;
    end
  end

  assign unlimited  = (st_i.retry_budget_ms == '0);
  assign host_down  = (item_i.status_class == sfrp_pkg::ST_HOST_DOWN);
  assign link_reset = (item_i.status_class == sfrp_pkg::ST_RESET);
  assign tmo_status = (item_i.status_class == sfrp_pkg::ST_TIMED_OUT);

  assign retries_inc = (&st_i.retries_total) ? st_i.retries_total : st_i.retries_total + 1'b1;
  assign fails_inc   = (&st_i.fails_on_server) ? st_i.fails_on_server
                                               : st_i.fails_on_server + 1'b1;
  assign wait_long   = retries_inc > sfrp_pkg::CNT32_W'(cfg_i.retries_before_wait);
  assign fails_hit   = st_i.fails_on_server >= sfrp_pkg::CNT32_W'(cfg_i.fails_before_switch);
  assign change      = !unlimited && (host_down || link_reset || fails_hit);
  assign timed_out   = !unlimited && !change && tmo_status;

  // doubled timeout, upper clamp first so a bad max loses to the base
  assign dbl      = {st_i.current_timeout_ms, 1'b0};
  assign clamp_hi = (dbl > (sfrp_pkg::TMO_W+1)'(cfg_i.max_timeout_ms))
                    ? (sfrp_pkg::TMO_W+1)'(cfg_i.max_timeout_ms) : dbl;
  assign clamp_lo = (clamp_hi < (sfrp_pkg::TMO_W+1)'(cfg_i.base_timeout_ms))
                    ? (sfrp_pkg::TMO_W+1)'(cfg_i.base_timeout_ms) : clamp_hi;

  assign inc_srv    = CW'(trying_i) + CW'(1);
  assign wrap_srv   = (inc_srv >= eff_count) ? '0 : inc_srv;
  assign seen_match = (working_i == seen_i);
  assign next_srv   = !seen_match ? working_i : (change ? SRV_W'(wrap_srv) : trying_i);
  assign same_srv   = (next_srv == trying_i);

  assign long_part = (unlimited && wait_long)
                     ? sfrp_pkg::DLY_W'(cfg_i.long_wait_ms) * sfrp_pkg::DLY_W'(sfrp_pkg::US_PER_MS)
                     : '0;
  assign delay = long_part
               + ((change && host_down) ? sfrp_pkg::DLY_W'(cfg_i.retry_interval_us) : '0)
               + ((same_srv && !timed_out) ? sfrp_pkg::DLY_W'(cfg_i.retry_interval_us) : '0);

  assign cur_next = !same_srv ? cfg_i.base_timeout_ms
                  : (timed_out ? clamp_lo[sfrp_pkg::TMO_W-1:0] : st_i.current_timeout_ms);

  assign elapsed = item_i.now_ms - st_i.start_time_ms;
  assign expired = !unlimited && (elapsed >= st_i.retry_budget_ms);

  // server indexes widened before cutting to the 3-bit result field
  assign trying_ext = (SRV_W+3)'(trying_i);
  assign next_ext   = (SRV_W+3)'(next_srv);

  always_comb begin
    st_o      = st_i;
    working_o = working_i;
    seen_o    = seen_i;
    trying_o  = trying_i;
    res_o     = '{action: sfrp_pkg::ACT_IGNORED, server_index: '0,
                  attempt_timeout_ms: '0, delay_us: '0};
    case (item_i.operation)
      sfrp_pkg::OP_START: begin
        seen_o                  = working_i;
        trying_o                = working_i;
        st_o.fails_on_server    = '0;
        st_o.retries_total      = '0;
        st_o.current_timeout_ms = cfg_i.base_timeout_ms;
        st_o.start_time_ms      = item_i.now_ms;
        st_o.retry_budget_ms    = item_i.budget_ms;
        st_o.request_active     = 1'b1;
        res_o.action             = sfrp_pkg::ACT_ISSUE;
        res_o.server_index       = sfrp_pkg::SRVF_W'((SRV_W+3)'(working_i));
        res_o.attempt_timeout_ms = cfg_i.base_timeout_ms;
      end
      sfrp_pkg::OP_SET_WORKING: begin
        if (CW'(item_i.new_working_server) < eff_count) begin
          working_o          = SRV_W'(item_i.new_working_server);
          res_o.action       = sfrp_pkg::ACT_UPDATE_ACK;
          res_o.server_index = item_i.new_working_server;
        end
      end
      sfrp_pkg::OP_RESULT: begin
        if (st_i.request_active) begin
          if (item_i.status_class == sfrp_pkg::ST_SUCCESS) begin
            working_o           = trying_i;
            st_o.request_active = 1'b0;
            res_o.action        = sfrp_pkg::ACT_DONE_OK;
            res_o.server_index  = trying_ext[sfrp_pkg::SRVF_W-1:0];
          end else begin
            if (unlimited) begin
              st_o.retries_total = retries_inc;
            end
            st_o.fails_on_server    = same_srv ? fails_inc : '0;
            st_o.current_timeout_ms = cur_next;
            seen_o                  = seen_match ? seen_i : working_i;
            trying_o                = next_srv;
            res_o.server_index      = next_ext[sfrp_pkg::SRVF_W-1:0];
            if (expired) begin
              st_o.request_active = 1'b0;
              res_o.action        = sfrp_pkg::ACT_DONE_EXPIRED;
            end else begin
              res_o.action             = sfrp_pkg::ACT_ISSUE;
              res_o.attempt_timeout_ms = cur_next;
              res_o.delay_us           = delay;
            end
          end
        end
      end
      default: begin
        res_o.action = sfrp_pkg::ACT_IGNORED;
      end
    endcase
  end

endmodule

// ----- hdl/server_failover_retry_policy.sv -----
// Retry policy with server failover and timeout backoff. Each input word (start, attempt
// result, working-server update) yields exactly one result word. Words pass an input
// register and a result register with the policy logic between them: one word per clock
// cycle sustained while the master side is ready. The input register loads on the
// accepting edge and the result register as the word leaves the input register, which
// is also when the policy state updates. A stalled master side holds the word in the
// input register and drops s_axis_tready_o only while both registers are full.
// Configuration writes take effect at the next edge and are meant for times when no
// word is in flight.
// depends on sfrp_pkg and sfrp_policy
module server_failover_retry_policy #(
  parameter int MAX_SERVERS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // status_class[2:0], now_ms[50:3], budget_ms[98:51], new_working_server[101:99], zero
  input  logic [103:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  // master side
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // server_index[2:0], attempt_timeout_ms[34:3], delay_us[61:35], zero
  output logic [63:0]  m_axis_tdata_o,
  // action[2:0]
  output logic [2:0]   m_axis_tuser_o,
  // configuration
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_wdata_i
);

  localparam int SRV_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW    = ($clog2(MAX_SERVERS + 1) > 4) ? $clog2(MAX_SERVERS + 1) : 4;

  sfrp_pkg::cfg_t       cfg_q;
  sfrp_pkg::item_t      in_q;
  logic                 in_valid_q;
  sfrp_pkg::result_t    out_q;
  logic                 out_valid_q;
  sfrp_pkg::req_state_t st_q, st_d;
  logic [SRV_W-1:0]     working_q, working_d;
  logic [SRV_W-1:0]     seen_q, seen_d;
  logic [SRV_W-1:0]     trying_q, trying_d;
  sfrp_pkg::result_t    res_d;
  sfrp_pkg::item_t      in_d;
  logic                 out_load;
  logic                 proc;
  logic                 in_acc;

  assign out_load        = !out_valid_q || m_axis_tready_i;
  assign proc            = in_valid_q && out_load;
  assign s_axis_tready_o = !in_valid_q || out_load;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_d = '{operation:          s_axis_tuser_i,
                  status_class:       s_axis_tdata_i[2:0],
                  now_ms:             s_axis_tdata_i[50:3],
                  budget_ms:          s_axis_tdata_i[98:51],
                  new_working_server: s_axis_tdata_i[101:99]};

  sfrp_policy #(
    .MAX_SERVERS (MAX_SERVERS),
    .SRV_W       (SRV_W),
    .CW          (CW)
  ) u_policy (
    .cfg_i     (cfg_q),
    .item_i    (in_q),
    .st_i      (st_q),
    .working_i (working_q),
    .seen_i    (seen_q),
    .trying_i  (trying_q),
    .st_o      (st_d),
    .working_o (working_d),
    .seen_o    (seen_d),
    .trying_o  (trying_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_timeout_ms     <= 32'd500;
      cfg_q.max_timeout_ms      <= 32'd8000;
      cfg_q.fails_before_switch <= 16'd3;
      cfg_q.retries_before_wait <= 16'd10;
      cfg_q.long_wait_ms        <= 16'd1000;
      cfg_q.retry_interval_us   <= 24'd100000;
      cfg_q.server_count        <= 4'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sfrp_pkg::CFG_BASE_TIMEOUT: cfg_q.base_timeout_ms     <= cfg_wdata_i;
        sfrp_pkg::CFG_MAX_TIMEOUT:  cfg_q.max_timeout_ms      <= cfg_wdata_i;
        sfrp_pkg::CFG_FAILS_SWITCH: cfg_q.fails_before_switch <= cfg_wdata_i[15:0];
        sfrp_pkg::CFG_RETRIES_WAIT: cfg_q.retries_before_wait <= cfg_wdata_i[15:0];
        sfrp_pkg::CFG_LONG_WAIT:    cfg_q.long_wait_ms        <= cfg_wdata_i[15:0];
        sfrp_pkg::CFG_RETRY_IVL:    cfg_q.retry_interval_us   <= cfg_wdata_i[23:0];
        sfrp_pkg::CFG_SERVER_COUNT: cfg_q.server_count        <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // policy state moves only when a word leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= '0;
      working_q <= '0;
      seen_q    <= '0;
      trying_q  <= '0;
    end else if (proc) begin
      st_q      <= st_d;
      working_q <= working_d;
      seen_q    <= seen_d;
      trying_q  <= trying_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_d;
    end
    if (proc) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.action;
  assign m_axis_tdata_o  = {2'b00, out_q.delay_us, out_q.attempt_timeout_ms, out_q.server_index};

`ifndef SYNTHESIS
  // only an issued attempt carries a timeout and a pause
  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != sfrp_pkg::ACT_ISSUE)) |-> (m_axis_tdata_o[61:3] == '0))
    else $error("non-issue result carries timeout or delay");

  // a request ends only through success or an expired budget
  a_request_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(st_q.request_active) |->
      $past(proc && ((res_d.action == sfrp_pkg::ACT_DONE_OK) ||
                     (res_d.action == sfrp_pkg::ACT_DONE_EXPIRED))))
    else $error("request ended without a done result");

  // a processed word always shows up as a result on the next cycle
  a_proc_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> m_axis_tvalid_o)
    else $error("processed word lost before the result register");
`endif

endmodule

// ----- bench/server_failover_retry_policy_test.sv -----
// testbench of server_failover_retry_policy: directed and random words, each result
// checked against an in-bench model of the retry, failover and backoff policy
// depends on sfrp_pkg and the rtl of the block
`timescale 1ns / 1ps

module server_failover_retry_policy_test;

  localparam int SERVERS_MAX = 8;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i;
  logic [1:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [63:0]  m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [31:0]  cfg_wdata_i;

  server_failover_retry_policy #(
    .MAX_SERVERS(SERVERS_MAX)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // register mirror, reset values
  logic [31:0] base_tmo        = 32'd500;
  logic [31:0] max_tmo         = 32'd8000;
  logic [15:0] fails_to_switch = 16'd3;
  logic [15:0] retries_to_wait = 16'd10;
  logic [15:0] long_wait       = 16'd1000;
  logic [23:0] retry_ivl       = 24'd100000;
  logic [3:0]  srv_count       = 4'd1;

  // policy state mirror
  logic [2:0]  work_srv    = '0;
  logic [2:0]  seen_srv    = '0;
  logic [2:0]  try_srv     = '0;
  logic [31:0] srv_fails   = '0;
  logic [31:0] retry_count = '0;
  logic [31:0] cur_tmo     = '0;
  logic [47:0] req_start   = '0;
  logic [47:0] req_budget  = '0;
  logic        req_busy    = 1'b0;

  sfrp_pkg::result_t awaited_results[$];
  int          words_in = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  int          act_seen[8];
  logic [47:0] clock_ms = '0;
  bit          src_steady = 1'b0;
  bit          sink_steady = 1'b0;
  int          sink_hold = 0;

  function automatic sfrp_pkg::result_t next_policy_result(logic [1:0] op, logic [2:0] st_in,
                                                           logic [47:0] now,
                                                           logic [47:0] budget,
                                                           logic [2:0] nws);
    sfrp_pkg::result_t r;
    logic [2:0]  st;
    logic [3:0]  ring;
    logic [3:0]  nxt;
    logic [32:0] dbl;
    logic [31:0] dly;
    logic        unlimited;
    logic        change;
    logic        timed_out;
    r.action = sfrp_pkg::ACT_IGNORED;
    r.server_index = '0;
    r.attempt_timeout_ms = '0;
    r.delay_us = '0;
    ring = (srv_count == 4'd0) ? 4'd1 :
           (srv_count > SERVERS_MAX) ? 4'(SERVERS_MAX) : srv_count;

    if (op == sfrp_pkg::OP_START) begin
      seen_srv = work_srv;
      try_srv = work_srv;
      srv_fails = '0;
      retry_count = '0;
      cur_tmo = base_tmo;
      req_start = now;
      req_budget = budget;
      req_busy = 1'b1;
      r.action = sfrp_pkg::ACT_ISSUE;
      r.server_index = try_srv;
      r.attempt_timeout_ms = cur_tmo;
      return r;
    end
    if (op == sfrp_pkg::OP_SET_WORKING) begin
      if ({1'b0, nws} < ring) begin
        work_srv = nws;
        r.action = sfrp_pkg::ACT_UPDATE_ACK;
        r.server_index = nws;
      end
      return r;
    end
    if (op != sfrp_pkg::OP_RESULT || !req_busy) return r;

    if (st_in == sfrp_pkg::ST_SUCCESS) begin
      work_srv = try_srv;
      req_busy = 1'b0;
      r.action = sfrp_pkg::ACT_DONE_OK;
      r.server_index = work_srv;
      return r;
    end

    // classes above other error fold into it
    st = (st_in > sfrp_pkg::ST_OTHER) ? sfrp_pkg::ST_OTHER : st_in;
    unlimited = (req_budget == '0);
    change = 1'b0;
    timed_out = 1'b0;
    dly = '0;
    if (unlimited) begin
      if (retry_count != '1) retry_count = retry_count + 32'd1;
      if (retry_count > retries_to_wait) dly = long_wait * 32'd1000;
    end else if (st == sfrp_pkg::ST_HOST_DOWN || st == sfrp_pkg::ST_RESET ||
                 srv_fails >= fails_to_switch) begin
      change = 1'b1;
      if (st == sfrp_pkg::ST_HOST_DOWN) dly = retry_ivl;
    end else if (st == sfrp_pkg::ST_TIMED_OUT) begin
      dbl = {cur_tmo, 1'b0};
      if (dbl > max_tmo) dbl = max_tmo;
      if (dbl < base_tmo) dbl = base_tmo;
      cur_tmo = dbl[31:0];
      timed_out = 1'b1;
    end

    // a working server changed by another user wins over the ring step
    if (work_srv == seen_srv) begin
      nxt = {1'b0, try_srv};
      if (change) begin
        nxt = nxt + 4'd1;
        if (nxt >= ring) nxt = '0;
      end
    end else begin
      seen_srv = work_srv;
      nxt = {1'b0, work_srv};
    end

    if (nxt[2:0] != try_srv) begin
      srv_fails = '0;
      cur_tmo = base_tmo;
    end else begin
      if (srv_fails != '1) srv_fails = srv_fails + 32'd1;
      if (!timed_out) dly = dly + retry_ivl;
    end
    try_srv = nxt[2:0];
    r.server_index = try_srv;

    if (!unlimited && (now - req_start) >= req_budget) begin
      req_busy = 1'b0;
      r.action = sfrp_pkg::ACT_DONE_EXPIRED;
    end else begin
      r.action = sfrp_pkg::ACT_ISSUE;
      r.attempt_timeout_ms = cur_tmo;
      r.delay_us = dly[26:0];
    end
    return r;
  endfunction

  function automatic void store_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      sfrp_pkg::CFG_BASE_TIMEOUT: base_tmo = v;
      sfrp_pkg::CFG_MAX_TIMEOUT:  max_tmo = v;
      sfrp_pkg::CFG_FAILS_SWITCH: fails_to_switch = v[15:0];
      sfrp_pkg::CFG_RETRIES_WAIT: retries_to_wait = v[15:0];
      sfrp_pkg::CFG_LONG_WAIT:    long_wait = v[15:0];
      sfrp_pkg::CFG_RETRY_IVL:    retry_ivl = v[23:0];
      sfrp_pkg::CFG_SERVER_COUNT: srv_count = v[3:0];
      default: ;
    endcase
  endfunction

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [2:0] pick_status();
    int p;
    p = $urandom_range(0, 99);
    if (p < 12) return sfrp_pkg::ST_SUCCESS;
    if (p < 30) return sfrp_pkg::ST_HOST_DOWN;
    if (p < 45) return sfrp_pkg::ST_RESET;
    if (p < 72) return sfrp_pkg::ST_TIMED_OUT;
    if (p < 88) return sfrp_pkg::ST_OTHER;
    return 3'($urandom_range(5, 7));
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [2:0] st, input logic [47:0] now,
                           input logic [47:0] budget, input logic [2:0] nws);
    int      gap;
    sfrp_pkg::result_t r;
    gap = src_steady ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {2'b00, nws, budget, now, st};
    s_axis_tuser_i <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    r = next_policy_result(op, st, now, budget, nws);
    awaited_results.push_back(r);
    words_in++;
  endtask

  // waits out every pending result plus the two-stage pipe before touching registers
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] base, input logic [31:0] maxv,
                              input logic [15:0] fails, input logic [15:0] retries,
                              input logic [15:0] longw, input logic [23:0] ivl,
                              input logic [3:0] count);
    logic [31:0] vals[7];
    logic [2:0]  idxs[7];
    vals = '{base, maxv, fails, retries, longw, ivl, count};
    idxs = '{sfrp_pkg::CFG_BASE_TIMEOUT, sfrp_pkg::CFG_MAX_TIMEOUT,
             sfrp_pkg::CFG_FAILS_SWITCH, sfrp_pkg::CFG_RETRIES_WAIT,
             sfrp_pkg::CFG_LONG_WAIT, sfrp_pkg::CFG_RETRY_IVL,
             sfrp_pkg::CFG_SERVER_COUNT};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idxs[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      store_reg(idxs[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // reset configuration: one server, so index 7 is out of the ring
  task automatic test_idle_and_updates();
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_TIMED_OUT, '0, '0, 3'd0);
    send_word(2'd3, 3'd7, '1, '1, 3'd7);
    send_word(sfrp_pkg::OP_SET_WORKING, sfrp_pkg::ST_SUCCESS, '0, '0, 3'd7);
    send_word(sfrp_pkg::OP_SET_WORKING, sfrp_pkg::ST_SUCCESS, '0, '0, 3'd0);
  endtask

  task automatic test_limited_failover();
    drain();
    program_regs(32'd100, 32'd400, 16'd2, 16'd10, 16'd1000, 24'd250, 4'd3);
    send_word(sfrp_pkg::OP_START, sfrp_pkg::ST_SUCCESS, 48'd1000, 48'd10000, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_TIMED_OUT, 48'd1100, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_TIMED_OUT, 48'd1200, '0, 3'd0);
    // third failure on one server moves on
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_TIMED_OUT, 48'd1300, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_HOST_DOWN, 48'd1400, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_RESET, 48'd1500, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, 3'd7, 48'd1600, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_SUCCESS, 48'd1700, '0, 3'd0);
  endtask

  task automatic test_unlimited_long_wait();
    drain();
    program_regs(32'd1, 32'hFFFF_FFFF, 16'd0, 16'd1, 16'hFFFF, 24'hFF_FFFF, 4'd8);
    send_word(sfrp_pkg::OP_SET_WORKING, sfrp_pkg::ST_SUCCESS, '0, '0, 3'd5);
    send_word(sfrp_pkg::OP_START, sfrp_pkg::ST_SUCCESS, '0, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_OTHER, 48'd10, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_HOST_DOWN, 48'd20, '0, 3'd0);
    // another user moves the working server mid-request
    send_word(sfrp_pkg::OP_SET_WORKING, sfrp_pkg::ST_SUCCESS, 48'd25, '0, 3'd2);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_TIMED_OUT, 48'd30, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_SUCCESS, 48'd40, '0, 3'd0);
  endtask

  // inverted clamp, zero server count, clock wrap, restart while busy, expiry
  task automatic test_budget_and_wrap();
    drain();
    program_regs(32'hFFFF_FFFF, 32'd1, 16'hFFFF, 16'd0, 16'd0, 24'd0, 4'd0);
    send_word(sfrp_pkg::OP_START, sfrp_pkg::ST_SUCCESS, 48'hFFFF_FFFF_FFF6, '1, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_TIMED_OUT, 48'd5, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_HOST_DOWN, 48'd6, '0, 3'd0);
    send_word(sfrp_pkg::OP_START, sfrp_pkg::ST_SUCCESS, 48'd100, 48'd1, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_OTHER, 48'd101, '0, 3'd0);
    send_word(sfrp_pkg::OP_RESULT, sfrp_pkg::ST_OTHER, 48'd102, '0, 3'd0);
  endtask

  task automatic random_request();
    int          n;
    int          p;
    logic [47:0] budget;
    logic [2:0]  st;
    p = $urandom_range(0, 99);
    if (p < 30) budget = '0;
    else if (p < 75) budget = 48'($urandom_range(1, 3000));
    else if (p < 90) budget = rand48();
    else budget = '1;
    p = $urandom_range(0, 99);
    if (p < 3) clock_ms = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3000));
    else if (p < 6) clock_ms = rand48();
    send_word(sfrp_pkg::OP_START, 3'($urandom), clock_ms, budget, 3'($urandom));
    n = $urandom_range(1, 14);
    for (int k = 0; k < n; k++) begin
      clock_ms = clock_ms + 48'($urandom_range(0, 400));
      if ($urandom_range(0, 11) == 0) begin
        send_word(sfrp_pkg::OP_SET_WORKING, 3'($urandom), clock_ms, rand48(), 3'($urandom));
      end else begin
        st = pick_status();
        send_word(sfrp_pkg::OP_RESULT, st, clock_ms, rand48(), 3'($urandom));
        if (st == sfrp_pkg::ST_SUCCESS) break;
      end
    end
  endtask

  task automatic test_random_traffic();
    int goal;
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      case (phase)
        0: program_regs(32'd500, 32'd8000, 16'd3, 16'd10, 16'd1000, 24'd100000, 4'd4);
        1: program_regs(32'd1, 32'd1, 16'd0, 16'd0, 16'd0, 24'd0, 4'd1);
        2: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        24'hFF_FFFF, 4'd8);
        3: program_regs(32'd3000, 32'd700, 16'd1, 16'd3, 16'd50, 24'd1000, 4'd15);
        default: begin
          program_regs(($urandom_range(0, 3) == 0) ? ($urandom | 32'd1) : $urandom_range(1, 3000),
                       ($urandom_range(0, 3) == 0) ? ($urandom | 32'd1) : $urandom_range(1, 9000),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)),
                       16'($urandom), 24'($urandom), 4'($urandom_range(1, 8)));
        end
      endcase
      src_steady = (phase % 4 == 1);
      sink_steady = (phase % 4 == 1) || (phase % 4 == 2);
      goal = words_in + 200;
      while (words_in < goal) begin
        if ($urandom_range(0, 9) == 0)
          send_word(2'($urandom_range(0, 3)), 3'($urandom), rand48(), rand48(), 3'($urandom));
        else
          random_request();
      end
    end
    src_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!sink_steady && $urandom_range(0, 3) == 0) sink_hold <= idle_len();
    end
  end

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    sfrp_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result word with nothing pending, action %0d", $time, m_axis_tuser_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        results_checked++;
        act_seen[want.action]++;
        check_field("action", 32'(want.action), 32'(m_axis_tuser_o));
        check_field("server_index", 32'(want.server_index), 32'(m_axis_tdata_o[2:0]));
        check_field("attempt_timeout_ms", want.attempt_timeout_ms, m_axis_tdata_o[34:3]);
        check_field("delay_us", 32'(want.delay_us), 32'(m_axis_tdata_o[61:35]));
      end
    end
  end

  initial begin
    #(8_000_000);
    $display("%0t: timed out with %0d results pending", $time, awaited_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_and_updates();
    test_limited_failover();
    test_unlimited_long_wait();
    test_budget_and_wrap();
    test_random_traffic();
    drain();

    $display("%0d words sent, %0d results checked, %0d mismatches", words_in,
             results_checked, mismatches);
    $display("attempts %0d, successes %0d, expiries %0d, updates %0d, ignored %0d",
             act_seen[sfrp_pkg::ACT_ISSUE], act_seen[sfrp_pkg::ACT_DONE_OK],
             act_seen[sfrp_pkg::ACT_DONE_EXPIRED], act_seen[sfrp_pkg::ACT_UPDATE_ACK],
             act_seen[sfrp_pkg::ACT_IGNORED]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- server_failover_retry_policy.f -----
hdl/sfrp_pkg.sv
hdl/sfrp_policy.sv
hdl/server_failover_retry_policy.sv
bench/server_failover_retry_policy_test.sv
